// ===== hw/rtl/cpu_ready_queue_scheduler_macros.svh =====
// assertion macros for the ready queue scheduler checker
`ifndef CPU_READY_QUEUE_SCHEDULER_MACROS_SVH
`define CPU_READY_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define CRQS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/crqs_pkg.sv =====
// shared types, codes and constants for the ready queue scheduler
package crqs_pkg;

   localparam int DEF_MAX_PROCS = 64;
   localparam int DEF_MAX_CPUS  = 8;
   localparam int DEF_TOP_LEVEL = 3;

   localparam int ACT_W   = 3;
   localparam int CPU_W   = 3;
   localparam int PID_W   = 6;
   localparam int PRIO_W  = 4;
   localparam int TIME_W  = 32;
   localparam int SLICE_W = 17;
   localparam int MODE_W  = 2;
   localparam int NCPU_W  = 4;
   localparam int K_W     = 4;

   localparam int RESULT_CAP = 8;

   localparam int REQ_W      = 48;
   localparam int RSP_W      = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int RSP_VALID_POS = 3;
   localparam int RSP_PROC_LSB  = 4;
   localparam int RSP_SLICE_LSB = 10;

   localparam logic [ACT_W-1:0] ACT_WAKE      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PREEMPT   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_YIELD     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_TERMINATE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_IDLE      = 3'd4;

   localparam logic [MODE_W-1:0] MODE_FIFO   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RR     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STATIC = 2'd2;
   localparam logic [MODE_W-1:0] MODE_MULTI  = 2'd3;

   localparam logic KIND_DISPATCH = 1'b0;
   localparam logic KIND_PREEMPT  = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLICE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAIT  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NCPU  = 2'd3;

   localparam logic [SLICE_W-1:0] SLICE_NONE = 17'h1FFFF;
   localparam logic [NCPU_W-1:0]  NCPU_RESET = 4'd8;

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [PRIO_W-1:0] prio;
   } qent_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DEC, S_WMASK, S_WSCAN, S_WEMIT, S_LVRD, S_LVUP, S_DISP,
      S_AGRQ, S_AGRL, S_AGCHK, S_CPRD, S_CPWR, S_CHKE, S_PKRQ, S_PKRL,
      S_PKCHK, S_TKRQ, S_TKSET, S_SHRQ, S_SHWR, S_FIN, S_EMPTY
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LATCH, OP_ENQ_NEW, OP_MASK, OP_WSTEP, OP_WEMIT, OP_LV_RD,
      OP_PRE, OP_YLD, OP_AG_INIT, OP_AG_RQ, OP_AG_RL, OP_AG_CHK, OP_CP_RD,
      OP_CP_WR, OP_PK_INIT, OP_PK_RQ, OP_PK_RL, OP_PK_CHK, OP_TK_RQ,
      OP_TK_SET, OP_SH_RQ, OP_SH_WR, OP_DONE_EMIT, OP_EMPTY_EMIT
   } op_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [MODE_W-1:0] mode;
      logic              proc_ok;
      logic              cpu_ok;
      logic              run_valid;
      logic              scan_more;
      logic              cp_more;
      logic              sh_more;
      logic              q_empty;
      logic              w_more;
      logic              w_hit;
      logic              out_free;
   } sts_type;

endpackage

// ===== hw/rtl/cpu_ready_queue_scheduler.sv =====
// ready queue scheduler for a set of cpus: fifo, round robin, static priority, multilevel
//
// req channel: one event word per handshake (wake, preempt, yield, terminate, idle).
// rsp channel: result words; a dispatch for the named cpu, or on a wake in static
// priority mode one preemption request per cpu that is idle or runs a lower
// priority, tlast on the final word of the event.
// csr port: plain register writes, to be issued only while the block is idle.
// an event is taken only while the sequencer is idle; one event at a time.
// a wake enqueues the process; in static priority mode it then scans the cpu
// positions up to MAX_CPUS and emits each request. a dispatch reads the level
// of a running process that is preempted or yields, runs the ageing pass in
// multilevel mode, scans the queued entries for the priority in static priority
// and multilevel mode, and moves down the entries after the chosen one; the
// single read port of the queue memory paces these passes.
// reset empties the queue, marks every cpu idle, clears levels and wait times
// and loads the register defaults; no clearing pass is needed.
// a stalled receiver holds the result word in the output register and the
// sequencer waits for it before loading the next word.
module cpu_ready_queue_scheduler #(
   parameter int MAX_PROCS = crqs_pkg::DEF_MAX_PROCS,
   parameter int MAX_CPUS  = crqs_pkg::DEF_MAX_CPUS,
   parameter int TOP_LEVEL = crqs_pkg::DEF_TOP_LEVEL
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action, cpu, proc, prio, now
   input  logic [crqs_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // target_cpu, proc_valid, proc_out, slice, zero fill
   output logic [crqs_pkg::RSP_W-1:0]      rsp_tdata,
   // kind
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_wen,
   input  logic [crqs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [crqs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import crqs_pkg::*;

   op_type  op;
   sts_type sts;

   crqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .op         (op)
   );

   crqs_datapath #(
      .MAX_PROCS (MAX_PROCS),
      .MAX_CPUS  (MAX_CPUS),
      .TOP_LEVEL (TOP_LEVEL)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/crqs_ctrl.sv =====
// sequencing state machine of the ready queue scheduler
module crqs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  crqs_pkg::sts_type sts,
   output crqs_pkg::op_type  op
);
   import crqs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = OP_NOP;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = OP_LATCH;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.action == ACT_WAKE) begin
               if (!sts.proc_ok) begin
                  state_in = S_IDLE;
               end else begin
                  op       = OP_ENQ_NEW;
                  state_in = (sts.mode == MODE_STATIC) ? S_WMASK : S_IDLE;
               end
            end else if (sts.action > ACT_IDLE || !sts.cpu_ok) begin
               state_in = S_IDLE;
            end else if (sts.run_valid &&
                         (sts.action == ACT_PREEMPT || sts.action == ACT_YIELD)) begin
               state_in = S_LVRD;
            end else begin
               state_in = S_DISP;
            end
         end
         S_WMASK: begin
            op       = OP_MASK;
            state_in = S_WSCAN;
         end
         S_WSCAN: begin
            if (!sts.w_more) begin
               state_in = S_IDLE;
            end else if (sts.w_hit) begin
               state_in = S_WEMIT;
            end else begin
               op = OP_WSTEP;
            end
         end
         S_WEMIT: begin
            if (sts.out_free) begin
               op       = OP_WEMIT;
               state_in = S_WSCAN;
            end
         end
         S_LVRD: begin
            op       = OP_LV_RD;
            state_in = S_LVUP;
         end
         S_LVUP: begin
            op       = (sts.action == ACT_PREEMPT) ? OP_PRE : OP_YLD;
            state_in = S_DISP;
         end
         S_DISP: begin
            if (sts.mode == MODE_MULTI) begin
               op       = OP_AG_INIT;
               state_in = S_AGRQ;
            end else begin
               state_in = S_CHKE;
            end
         end
         S_AGRQ: begin
            if (sts.scan_more) begin
               op       = OP_AG_RQ;
               state_in = S_AGRL;
            end else begin
               state_in = S_CPRD;
            end
         end
         S_AGRL: begin
            op       = OP_AG_RL;
            state_in = S_AGCHK;
         end
         S_AGCHK: begin
            op       = OP_AG_CHK;
            state_in = S_AGRQ;
         end
         S_CPRD: begin
            if (sts.cp_more) begin
               op       = OP_CP_RD;
               state_in = S_CPWR;
            end else begin
               state_in = S_CHKE;
            end
         end
         S_CPWR: begin
            op       = OP_CP_WR;
            state_in = S_CPRD;
         end
         S_CHKE: begin
            op = OP_PK_INIT;
            if (sts.q_empty) begin
               state_in = S_EMPTY;
            end else if (sts.mode == MODE_STATIC || sts.mode == MODE_MULTI) begin
               state_in = S_PKRQ;
            end else begin
               state_in = S_TKRQ;
            end
         end
         S_PKRQ: begin
            if (sts.scan_more) begin
               op       = OP_PK_RQ;
               state_in = S_PKRL;
            end else begin
               state_in = S_TKRQ;
            end
         end
         S_PKRL: begin
            op       = OP_PK_RL;
            state_in = S_PKCHK;
         end
         S_PKCHK: begin
            op       = OP_PK_CHK;
            state_in = S_PKRQ;
         end
         S_TKRQ: begin
            op       = OP_TK_RQ;
            state_in = S_TKSET;
         end
         S_TKSET: begin
            op       = OP_TK_SET;
            state_in = S_SHRQ;
         end
         S_SHRQ: begin
            if (sts.sh_more) begin
               op       = OP_SH_RQ;
               state_in = S_SHWR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SHWR: begin
            op       = OP_SH_WR;
            state_in = S_SHRQ;
         end
         S_FIN: begin
            if (sts.out_free) begin
               op       = OP_DONE_EMIT;
               state_in = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (sts.out_free) begin
               op       = OP_EMPTY_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/crqs_datapath.sv =====
// queue memories, process tables, cpu state and result register
module crqs_datapath #(
   parameter int MAX_PROCS = crqs_pkg::DEF_MAX_PROCS,
   parameter int MAX_CPUS  = crqs_pkg::DEF_MAX_CPUS,
   parameter int TOP_LEVEL = crqs_pkg::DEF_TOP_LEVEL
) (
   input  logic                              clock,
   input  logic                              reset,
   input  crqs_pkg::op_type                  op,
   output crqs_pkg::sts_type                 sts,
   input  logic [crqs_pkg::REQ_W-1:0]        req_tdata,
   input  logic                              csr_wen,
   input  logic [crqs_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [crqs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [crqs_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import crqs_pkg::*;

   localparam int PW   = $clog2(MAX_PROCS);
   localparam int CNTW = $clog2(MAX_PROCS + 1);
   localparam int CW   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
   localparam int CIW  = $clog2(MAX_CPUS + 1);
   localparam int LVW  = $clog2(TOP_LEVEL + 1);

   // configuration
   logic [MODE_W-1:0]  mode_ff;
   logic [SLICE_W-1:0] slice_ff;
   logic [TIME_W-1:0]  wl_ff;
   logic [NCPU_W-1:0]  ncpu_ff;

   // latched word
   logic [ACT_W-1:0]  act_ff;
   logic [CPU_W-1:0]  cpu_ff;
   logic [PID_W-1:0]  pid_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [TIME_W-1:0] now_ff;

   // cpu state
   logic [MAX_CPUS-1:0] rv_ff;
   logic [PID_W-1:0]    rpid_ff [MAX_CPUS];
   logic [PRIO_W-1:0]   rpr_ff  [MAX_CPUS];
   logic [MAX_CPUS-1:0] mask_ff;
   logic [MAX_CPUS-1:0] mask_in;
   logic [CIW-1:0]      wi_ff;
   logic [K_W-1:0]      k_ff;

   // queue
   qent_type        qmem [MAX_PROCS];
   qent_type        tmem [MAX_PROCS];
   qent_type        qrd_ff, trd_ff;
   logic [CNTW-1:0] count_ff, i_ff, nk_ff, na_ff, j_ff, pick_ff;
   logic [PRIO_W-1:0] best_ff;
   logic [PID_W-1:0]  take_pid_ff;

   // per-process tables
   logic [LVW-1:0]       lmem [MAX_PROCS];
   logic [TIME_W-1:0]    wmem [MAX_PROCS];
   logic [MAX_PROCS-1:0] lval_ff, wval_ff;
   logic [LVW-1:0]       lrd_ff;
   logic [TIME_W-1:0]    wrd_ff;
   logic                 lrv_ff, wrv_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [CPU_W-1:0]   rsp_cpu_ff;
   logic               rsp_pv_ff;
   logic [PID_W-1:0]   rsp_pid_ff;
   logic [SLICE_W-1:0] rsp_slice_ff;
   logic               rsp_last_ff;

   logic              q_re, q_we, t_re, t_we, l_re, l_we, w_we;
   logic [PW-1:0]     qra, qwa, tra, twa, la;
   qent_type          qwd, twd;
   logic [LVW-1:0]    lwd;
   logic [TIME_W-1:0] wwd;

   logic [31:0]       cpu_w, run_pid_w, q_pid_w, wi_w;
   logic [CW-1:0]     cidx;
   logic [PID_W-1:0]  run_pid;
   logic [PRIO_W-1:0] run_pr;
   logic [LVW-1:0]    lvl;
   logic [TIME_W-1:0] wst;
   logic              q_full, aged, out_free, w_last;
   logic [PRIO_W-1:0] key;
   logic [CNTW-1:0]   nkj, i_inc;
   logic [CIW-1:0]    wi_inc;
   logic [MAX_CPUS-1:0] rest;

   assign cpu_w     = 32'(cpu_ff);
   assign cidx      = cpu_w[CW-1:0];
   assign run_pid   = rpid_ff[cidx];
   assign run_pr    = rpr_ff[cidx];
   assign run_pid_w = 32'(run_pid);
   assign q_pid_w   = 32'(qrd_ff.pid);
   assign wi_w      = 32'(wi_ff);
   assign lvl       = lrv_ff ? lrd_ff : '0;
   assign wst       = wrv_ff ? wrd_ff : '0;
   assign q_full    = (count_ff >= CNTW'(MAX_PROCS));
   assign aged      = ({1'b0, now_ff} > ({1'b0, wst} + {1'b0, wl_ff})) &&
                      (lvl < LVW'(TOP_LEVEL));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign key       = (mode_ff == MODE_STATIC) ? qrd_ff.prio : PRIO_W'(lvl);
   assign nkj       = nk_ff + j_ff;
   assign i_inc     = i_ff + CNTW'(1);
   assign wi_inc    = wi_ff + CIW'(1);
   assign rest      = mask_ff >> wi_inc;
   assign w_last    = (k_ff == K_W'(RESULT_CAP - 1)) || (rest == '0);

   always_comb begin
      for (int g = 0; g < MAX_CPUS; g++) begin
         mask_in[g] = ({28'd0, ncpu_ff} > 32'(g)) && (!rv_ff[g] || prio_ff > rpr_ff[g]);
      end
   end

   always_comb begin
      sts.action    = act_ff;
      sts.mode      = mode_ff;
      sts.proc_ok   = (32'(pid_ff) < MAX_PROCS);
      sts.cpu_ok    = (cpu_w < MAX_CPUS);
      sts.run_valid = rv_ff[cidx];
      sts.scan_more = (i_ff < count_ff);
      sts.cp_more   = (j_ff < na_ff);
      sts.sh_more   = ({1'b0, i_ff} + {{CNTW{1'b0}}, 1'b1}) < {1'b0, count_ff};
      sts.q_empty   = (count_ff == '0);
      sts.w_more    = (wi_w < MAX_CPUS) && (k_ff < K_W'(RESULT_CAP));
      sts.w_hit     = mask_ff[wi_w[CW-1:0]];
      sts.out_free  = out_free;
   end

   always_comb begin
      q_re = 1'b0;
      q_we = 1'b0;
      t_re = 1'b0;
      t_we = 1'b0;
      l_re = 1'b0;
      l_we = 1'b0;
      w_we = 1'b0;
      qra  = i_ff[PW-1:0];
      qwa  = count_ff[PW-1:0];
      qwd  = qrd_ff;
      tra  = j_ff[PW-1:0];
      twa  = na_ff[PW-1:0];
      twd  = qrd_ff;
      lwd  = lvl + LVW'(1);
      wwd  = now_ff;
      if (op == OP_LV_RD || op == OP_PRE || op == OP_YLD) begin
         la = run_pid_w[PW-1:0];
      end else begin
         la = q_pid_w[PW-1:0];
      end
      case (op)
         OP_ENQ_NEW: begin
            q_we = !q_full;
            qwd  = '{pid: pid_ff, prio: prio_ff};
         end
         OP_LV_RD: l_re = 1'b1;
         OP_PRE: begin
            if (mode_ff == MODE_MULTI && lvl != '0) begin
               l_we = 1'b1;
               w_we = 1'b1;
               lwd  = lvl - LVW'(1);
            end
            q_we = !q_full;
            qwd  = '{pid: run_pid, prio: run_pr};
         end
         OP_YLD: begin
            if (mode_ff == MODE_MULTI && lvl < LVW'(TOP_LEVEL)) begin
               l_we = 1'b1;
               w_we = 1'b1;
            end
         end
         OP_AG_RQ, OP_PK_RQ: q_re = 1'b1;
         OP_AG_RL, OP_PK_RL: l_re = 1'b1;
         OP_AG_CHK: begin
            if (aged) begin
               l_we = 1'b1;
               t_we = 1'b1;
            end else begin
               q_we = 1'b1;
               qwa  = nk_ff[PW-1:0];
            end
         end
         OP_CP_RD: t_re = 1'b1;
         OP_CP_WR: begin
            q_we = 1'b1;
            qwa  = nkj[PW-1:0];
            qwd  = trd_ff;
         end
         OP_TK_RQ: begin
            q_re = 1'b1;
            qra  = pick_ff[PW-1:0];
         end
         OP_SH_RQ: begin
            q_re = 1'b1;
            qra  = i_inc[PW-1:0];
         end
         OP_SH_WR: begin
            q_we = 1'b1;
            qwa  = i_ff[PW-1:0];
         end
         default: ;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (q_we) qmem[qwa] <= qwd;
      if (q_re) qrd_ff <= qmem[qra];
      if (t_we) tmem[twa] <= twd;
      if (t_re) trd_ff <= tmem[tra];
      if (l_we) lmem[la] <= lwd;
      if (w_we) wmem[la] <= wwd;
      if (l_re) begin
         lrd_ff <= lmem[la];
         wrd_ff <= wmem[la];
         lrv_ff <= lval_ff[la];
         wrv_ff <= wval_ff[la];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lval_ff <= '0;
         wval_ff <= '0;
      end else begin
         if (l_we) lval_ff[la] <= 1'b1;
         if (w_we) wval_ff[la] <= 1'b1;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FIFO;
         slice_ff <= SLICE_NONE;
         wl_ff    <= '0;
         ncpu_ff  <= NCPU_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_MODE:  mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_SLICE: slice_ff <= csr_wdata[SLICE_W-1:0];
            CSR_WAIT:  wl_ff    <= csr_wdata[TIME_W-1:0];
            CSR_NCPU:  ncpu_ff  <= csr_wdata[NCPU_W-1:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op == OP_DONE_EMIT || op == OP_EMPTY_EMIT || op == OP_WEMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (op)
            OP_ENQ_NEW, OP_PRE: begin
               if (!q_full) count_ff <= count_ff + CNTW'(1);
            end
            OP_TK_SET:     rv_ff[cidx] <= 1'b1;
            OP_DONE_EMIT:  count_ff <= count_ff - CNTW'(1);
            OP_EMPTY_EMIT: rv_ff[cidx] <= 1'b0;
            default: ;
         endcase
      end
   end

   // working registers and result payload
   always_ff @(posedge clock) begin
      case (op)
         OP_LATCH: begin
            act_ff  <= req_tdata[2:0];
            cpu_ff  <= req_tdata[5:3];
            pid_ff  <= req_tdata[11:6];
            prio_ff <= req_tdata[15:12];
            now_ff  <= req_tdata[47:16];
         end
         OP_MASK: begin
            mask_ff <= mask_in;
            wi_ff   <= '0;
            k_ff    <= '0;
         end
         OP_WSTEP: wi_ff <= wi_inc;
         OP_WEMIT: begin
            rsp_kind_ff  <= KIND_PREEMPT;
            rsp_cpu_ff   <= wi_w[CPU_W-1:0];
            rsp_pv_ff    <= 1'b0;
            rsp_pid_ff   <= '0;
            rsp_slice_ff <= '0;
            rsp_last_ff  <= w_last;
            wi_ff        <= wi_inc;
            k_ff         <= k_ff + K_W'(1);
         end
         OP_AG_INIT: begin
            i_ff  <= '0;
            nk_ff <= '0;
            na_ff <= '0;
            j_ff  <= '0;
         end
         OP_AG_CHK: begin
            if (aged) na_ff <= na_ff + CNTW'(1);
            else      nk_ff <= nk_ff + CNTW'(1);
            i_ff <= i_inc;
         end
         OP_CP_WR: j_ff <= j_ff + CNTW'(1);
         OP_PK_INIT: begin
            i_ff    <= '0;
            pick_ff <= '0;
            best_ff <= '0;
         end
         OP_PK_CHK: begin
            if (i_ff == '0 || key > best_ff) begin
               best_ff <= key;
               pick_ff <= i_ff;
            end
            i_ff <= i_inc;
         end
         OP_TK_RQ: i_ff <= pick_ff;
         OP_TK_SET: begin
            rpid_ff[cidx] <= qrd_ff.pid;
            rpr_ff[cidx]  <= qrd_ff.prio;
            take_pid_ff   <= qrd_ff.pid;
         end
         OP_SH_WR: i_ff <= i_inc;
         OP_DONE_EMIT: begin
            rsp_kind_ff  <= KIND_DISPATCH;
            rsp_cpu_ff   <= cpu_ff;
            rsp_pv_ff    <= 1'b1;
            rsp_pid_ff   <= take_pid_ff;
            rsp_slice_ff <= slice_ff;
            rsp_last_ff  <= 1'b1;
         end
         OP_EMPTY_EMIT: begin
            rsp_kind_ff  <= KIND_DISPATCH;
            rsp_cpu_ff   <= cpu_ff;
            rsp_pv_ff    <= 1'b0;
            rsp_pid_ff   <= '0;
            rsp_slice_ff <= slice_ff;
            rsp_last_ff  <= 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_slice_ff, rsp_pid_ff, rsp_pv_ff, rsp_cpu_ff};

endmodule

// ===== hw/rtl/crqs_checker.sv =====
// port-level checks for the ready queue scheduler, bound to the top level
`include "cpu_ready_queue_scheduler_macros.svh"

module crqs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [crqs_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tuser,
   input logic                       rsp_tlast
);
   import crqs_pkg::*;

   `CRQS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word dropped or changed while stalled")
   `CRQS_ASSERT_NOW(a_dispatch_last, rsp_tvalid && rsp_tuser == KIND_DISPATCH, rsp_tlast, "dispatch word without tlast")
   `CRQS_ASSERT_NOW(a_preempt_fields, rsp_tvalid && rsp_tuser == KIND_PREEMPT, !rsp_tdata[RSP_VALID_POS] && rsp_tdata[RSP_SLICE_LSB+SLICE_W-1:RSP_SLICE_LSB] == '0, "preemption word carries a process or slice")
   `CRQS_ASSERT_NEXT(a_busy_mid_event, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready, "new event taken before the current one finished")

endmodule

bind cpu_ready_queue_scheduler crqs_checker u_checker (.*);
